### sv/pbb_pkg.sv
// Package for the PID bang-bang controller: widths, reset values, register
// indexes and the configuration struct shared by pbb_csr, pbb_law and the top level.
// Depends on nothing.
package pbb_pkg;

   localparam int SAMPLE_BITS = 10;
   localparam int GAIN_BITS   = 16;
   localparam int LIMIT_BITS  = 10;
   localparam int LEVEL_BITS  = 10;
   localparam int TERM_BITS   = 28;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // The accumulator must hold any clamp value and any single error.
   localparam int ACC_BITS  = ((SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS) + 1;
   localparam int ERR_BITS  = SAMPLE_BITS + 1;
   localparam int PROD_BITS = ACC_BITS + GAIN_BITS + 1;
   localparam int SUM_BITS  = PROD_BITS + 2;

   localparam logic [GAIN_BITS-1:0]   PROP_GAIN_RESET   = GAIN_BITS'(4829);
   localparam logic [GAIN_BITS-1:0]   INTEG_GAIN_RESET  = GAIN_BITS'(4348);
   localparam logic [GAIN_BITS-1:0]   DERIV_GAIN_RESET  = GAIN_BITS'(3373);
   localparam logic [LIMIT_BITS-1:0]  INTEG_LIMIT_RESET = LIMIT_BITS'(25);
   localparam logic [LEVEL_BITS-1:0]  DRIVE_HIGH_RESET  = LEVEL_BITS'(1023);
   localparam logic [SAMPLE_BITS-1:0] LAST_MEAS_RESET   = SAMPLE_BITS'(1000);

   localparam logic signed [SUM_BITS-1:0] TERM_MAX = SUM_BITS'(2 ** (TERM_BITS - 1) - 1);
   localparam logic signed [SUM_BITS-1:0] TERM_MIN = -TERM_MAX - SUM_BITS'(1);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PROP_GAIN   = 3'd0,
      CSR_INTEG_GAIN  = 3'd1,
      CSR_DERIV_GAIN  = 3'd2,
      CSR_INTEG_LIMIT = 3'd3,
      CSR_DRIVE_HIGH  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_BITS-1:0]  prop_gain;
      logic [GAIN_BITS-1:0]  integ_gain;
      logic [GAIN_BITS-1:0]  deriv_gain;
      logic [LIMIT_BITS-1:0] integ_limit;
      logic [LEVEL_BITS-1:0] drive_high;
   } cfg_type;

endpackage

### sv/pbb_req_if.sv
// Sample channel of the PID bang-bang controller: valid/ready plus one
// measured and one setpoint sample. Depends on pbb_pkg.
interface pbb_req_if;
   logic                             valid;
   logic                             ready;
   logic [pbb_pkg::SAMPLE_BITS-1:0]  measured;
   logic [pbb_pkg::SAMPLE_BITS-1:0]  target;

   modport source (output valid, measured, target, input ready);
   modport sink (input valid, measured, target, output ready);
endinterface

### sv/pbb_rsp_if.sv
// Result channel of the PID bang-bang controller: valid/ready plus the drive
// level and the saturated term sum. Depends on pbb_pkg.
interface pbb_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [pbb_pkg::LEVEL_BITS-1:0]        drive;
   logic signed [pbb_pkg::TERM_BITS-1:0]  term_sum;

   modport source (output valid, drive, term_sum, input ready);
   modport sink (input valid, drive, term_sum, output ready);
endinterface

### sv/pbb_csr.sv
// Configuration registers of the PID bang-bang controller (gains, clamp,
// output level). Depends on pbb_pkg.
module pbb_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [pbb_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pbb_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output pbb_pkg::cfg_type                    cfg
);

   pbb_pkg::cfg_type cfg_ff;
   pbb_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (pbb_pkg::csr_index_type'(csr_index))
            pbb_pkg::CSR_PROP_GAIN:   cfg_in.prop_gain  = csr_wdata[pbb_pkg::GAIN_BITS-1:0];
            pbb_pkg::CSR_INTEG_GAIN:  cfg_in.integ_gain = csr_wdata[pbb_pkg::GAIN_BITS-1:0];
            pbb_pkg::CSR_DERIV_GAIN:  cfg_in.deriv_gain = csr_wdata[pbb_pkg::GAIN_BITS-1:0];
            pbb_pkg::CSR_INTEG_LIMIT: cfg_in.integ_limit = csr_wdata[pbb_pkg::LIMIT_BITS-1:0];
            pbb_pkg::CSR_DRIVE_HIGH:  cfg_in.drive_high = csr_wdata[pbb_pkg::LEVEL_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain   <= pbb_pkg::PROP_GAIN_RESET;
         cfg_ff.integ_gain  <= pbb_pkg::INTEG_GAIN_RESET;
         cfg_ff.deriv_gain  <= pbb_pkg::DERIV_GAIN_RESET;
         cfg_ff.integ_limit <= pbb_pkg::INTEG_LIMIT_RESET;
         cfg_ff.drive_high  <= pbb_pkg::DRIVE_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/pbb_law.sv
// Control law of the PID bang-bang controller: clamped integral state,
// previous sample, the three gain products, their sum and the on/off decision.
// Depends on pbb_pkg.
module pbb_law (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  step,
   input  logic [pbb_pkg::SAMPLE_BITS-1:0]       measured,
   input  logic [pbb_pkg::SAMPLE_BITS-1:0]       target,
   input  pbb_pkg::cfg_type                      cfg,
   output logic [pbb_pkg::LEVEL_BITS-1:0]        drive,
   output logic signed [pbb_pkg::TERM_BITS-1:0]  term_sum
);

   logic signed [pbb_pkg::ACC_BITS-1:0]    integ_acc_ff;
   logic signed [pbb_pkg::ACC_BITS-1:0]    integ_acc_in;
   logic [pbb_pkg::SAMPLE_BITS-1:0]        last_measured_ff;

   logic signed [pbb_pkg::ERR_BITS-1:0]    err;
   logic signed [pbb_pkg::ERR_BITS-1:0]    delta;
   logic signed [pbb_pkg::ACC_BITS:0]      acc_sum;
   logic signed [pbb_pkg::ACC_BITS:0]      lim_pos;
   logic signed [pbb_pkg::ACC_BITS:0]      lim_neg;
   logic signed [pbb_pkg::PROD_BITS-1:0]   prop_term;
   logic signed [pbb_pkg::PROD_BITS-1:0]   integ_term;
   logic signed [pbb_pkg::PROD_BITS-1:0]   deriv_term;
   logic signed [pbb_pkg::SUM_BITS-1:0]    sum;
   logic signed [pbb_pkg::SUM_BITS-1:0]    sat;

   always_comb begin
      err   = $signed({1'b0, target}) - $signed({1'b0, measured});
      delta = $signed({1'b0, measured}) - $signed({1'b0, last_measured_ff});

      acc_sum = (pbb_pkg::ACC_BITS + 1)'(integ_acc_ff) + (pbb_pkg::ACC_BITS + 1)'(err);
      lim_pos = $signed((pbb_pkg::ACC_BITS + 1)'(cfg.integ_limit));
      lim_neg = -lim_pos;
      // Upper clamp first, then lower; a zero limit pins the state at zero.
      priority if (acc_sum > lim_pos) begin
         integ_acc_in = pbb_pkg::ACC_BITS'(lim_pos);
      end else if (acc_sum < lim_neg) begin
         integ_acc_in = pbb_pkg::ACC_BITS'(lim_neg);
      end else begin
         integ_acc_in = pbb_pkg::ACC_BITS'(acc_sum);
      end

      prop_term  = pbb_pkg::PROD_BITS'(err) *
                   $signed(pbb_pkg::PROD_BITS'(cfg.prop_gain));
      integ_term = pbb_pkg::PROD_BITS'(integ_acc_in) *
                   $signed(pbb_pkg::PROD_BITS'(cfg.integ_gain));
      deriv_term = pbb_pkg::PROD_BITS'(delta) *
                   $signed(pbb_pkg::PROD_BITS'(cfg.deriv_gain));

      sum = pbb_pkg::SUM_BITS'(prop_term) + pbb_pkg::SUM_BITS'(integ_term) +
            pbb_pkg::SUM_BITS'(deriv_term);

      priority if (sum > pbb_pkg::TERM_MAX) begin
         sat = pbb_pkg::TERM_MAX;
      end else if (sum < pbb_pkg::TERM_MIN) begin
         sat = pbb_pkg::TERM_MIN;
      end else begin
         sat = sum;
      end

      // The unsaturated sum decides the output level.
      drive    = sum[pbb_pkg::SUM_BITS-1] ? '0 : cfg.drive_high;
      term_sum = sat[pbb_pkg::TERM_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_acc_ff     <= '0;
         last_measured_ff <= pbb_pkg::LAST_MEAS_RESET;
      end else if (step) begin
         integ_acc_ff     <= integ_acc_in;
         last_measured_ff <= measured;
      end
   end

endmodule

### sv/pid_bang_bang_controller_core.sv
// Top level of the PID bang-bang controller: sample register, control law,
// result register and configuration registers.
// Depends on pbb_pkg, pbb_req_if, pbb_rsp_if, pbb_csr and pbb_law.

// The controller takes one measured/setpoint pair per clock while the result
// side is not stalled and returns one result per pair, in order: the on/off
// drive level and the saturated Q.12 sum of the proportional, integral and
// derivative terms. The result of a request transfer passes through the
// sample register and then the result register before it can itself
// transfer; throughput is one pair per cycle, bounded by the combinational
// control law between the sample register and the result register, which
// also updates the integral and previous-sample state. While a finished
// result waits to be taken, the sample register can take one more pair, and
// then the request side stalls until the result transfers. Configuration
// writes take effect on the next cycle and are meant for idle periods.
module pid_bang_bang_controller_core (
   input  logic                                clock,
   input  logic                                reset,
   pbb_req_if.sink                             req_ch,
   pbb_rsp_if.source                           rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [pbb_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pbb_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   pbb_pkg::cfg_type cfg;

   logic                                  in_valid_ff;
   logic                                  in_valid_in;
   logic [pbb_pkg::SAMPLE_BITS-1:0]       measured_ff;
   logic [pbb_pkg::SAMPLE_BITS-1:0]       target_ff;
   logic                                  out_valid_ff;
   logic                                  out_valid_in;
   logic [pbb_pkg::LEVEL_BITS-1:0]        drive_ff;
   logic signed [pbb_pkg::TERM_BITS-1:0]  term_sum_ff;

   logic                                  out_free;
   logic                                  advance;
   logic                                  req_take;
   logic [pbb_pkg::LEVEL_BITS-1:0]        law_drive;
   logic signed [pbb_pkg::TERM_BITS-1:0]  law_term_sum;

   pbb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pbb_law u_law (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .measured (measured_ff),
      .target   (target_ff),
      .cfg      (cfg),
      .drive    (law_drive),
      .term_sum (law_term_sum)
   );

   always_comb begin
      out_free     = !out_valid_ff || rsp_ch.ready;
      advance      = in_valid_ff && out_free;
      req_ch.ready = !in_valid_ff || out_free;
      req_take     = req_ch.valid && req_ch.ready;

      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         measured_ff <= req_ch.measured;
         target_ff   <= req_ch.target;
      end
      if (advance) begin
         drive_ff    <= law_drive;
         term_sum_ff <= law_term_sum;
      end
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.drive    = drive_ff;
   assign rsp_ch.term_sum = term_sum_ff;

endmodule

### sv/pbb_checker.sv
// Port-level checks for the PID bang-bang controller and the bind that
// attaches them to the top level. Depends on pbb_req_if and pbb_rsp_if.
module pbb_checker (
   input  logic        clock,
   input  logic        reset,
   pbb_req_if.sink     req_ch,
   pbb_rsp_if.source   rsp_ch
);

   // A negative term sum always means the output is off.
   a_negative_sum_off: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.term_sum[$bits(rsp_ch.term_sum)-1] |-> rsp_ch.drive == '0)
      else $error("drive is not zero for a negative term sum");

   // The sample side only stalls when the result side is full and stalled.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> rsp_ch.valid && !rsp_ch.ready)
      else $error("request stalled without a stalled result");

   // A reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

   // A stalled result holds until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=>
         rsp_ch.valid && $stable(rsp_ch.drive) && $stable(rsp_ch.term_sum))
      else $error("stalled result changed");

endmodule

bind pid_bang_bang_controller_core pbb_checker u_pbb_checker (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch)
);
